>>> rtl/kccl_pkg.sv
// Shared types, codes and constants of the keypad and card code lock.
package kccl_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_SECONDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SECONDS = 2'd2;

  localparam logic [3:0] MAX_FAILURES_RST = 4'd3;
  localparam logic [7:0] LOCKOUT_SECONDS_RST = 8'd10;
  localparam logic [7:0] HOLD_SECONDS_RST = 8'd3;

  localparam logic [3:0] FAIL_SAT = 4'hf;

  localparam logic [3:0] KEY_MAP [16] = '{
    4'd1, 4'd4, 4'd7, 4'd10, 4'd2, 4'd5, 4'd8, 4'd0,
    4'd3, 4'd6, 4'd9, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  typedef enum logic [1:0] {
    REQ_KEY  = 2'd0,
    REQ_CARD = 2'd1,
    REQ_TICK = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PH_SET_PASS = 2'd0,
    PH_SET_CARD = 2'd1,
    PH_ENTRY    = 2'd2,
    PH_LOCKED   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    HOLD_NONE   = 2'd0,
    HOLD_RELAY  = 2'd1,
    HOLD_BUZZER = 2'd2,
    HOLD_LED    = 2'd3
  } hold_e;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_KEY        = 4'd1,
    EV_PASS_SET   = 4'd2,
    EV_CARD_SET   = 4'd3,
    EV_CODE_OK    = 4'd4,
    EV_CODE_BAD   = 4'd5,
    EV_CARD_OK    = 4'd6,
    EV_CARD_BAD   = 4'd7,
    EV_LOCK_START = 4'd8,
    EV_LOCK_END   = 4'd9,
    EV_IGNORED    = 4'd10
  } event_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  key_code;
    logic [31:0] card_id;
  } kccl_in_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] event_code;
    logic [3:0] key_symbol;
    logic       relay_on;
    logic       buzzer_on;
    logic       set_led_on;
    logic [3:0] failures;
    logic [7:0] lockout_left;
    logic [2:0] digits_entered;
  } kccl_out_t;

  typedef struct packed {
    logic [3:0] max_failures;
    logic [7:0] lockout_seconds;
    logic [7:0] hold_seconds;
  } kccl_cfg_t;

endpackage

>>> rtl/kccl_core.sv
// Lock state registers and the single-pass update for one request.
module kccl_core #(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  kccl_pkg::kccl_in_t  item_i,
  input  kccl_pkg::kccl_cfg_t cfg_i,
  output kccl_pkg::kccl_out_t res_o
);

  localparam int unsigned IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [3:0] CODE_LEN4 = 4'(CODE_LENGTH);

  kccl_pkg::phase_e mode_q, mode_d;
  kccl_pkg::hold_e  hold_q, hold_d;
  kccl_pkg::event_e ev;
  kccl_pkg::req_e   req;
  logic [2:0]       dcnt_q, dcnt_d;
  logic [3:0]       fail_q, fail_d;
  logic [7:0]       htmr_q, htmr_d;
  logic [7:0]       ltmr_q, ltmr_d;
  logic             pend_q, pend_d;
  logic [3:0]       enr_q [CODE_LENGTH];
  logic [3:0]       ent_q [CODE_LENGTH];
  logic [31:0]      card_q;
  logic             enr_we, ent_we, card_we;

  logic [3:0]       sym;
  logic             busy;
  logic [3:0]       cnt_inc;
  logic             done;
  logic [IDX_W-1:0] didx;
  logic             code_match;
  logic [3:0]       fail_inc;
  logic [7:0]       hold_len, lock_len, htmr_dec, ltmr_dec;

  assign req      = kccl_pkg::req_e'(item_i.req_type);
  assign sym      = (req == kccl_pkg::REQ_KEY) ? kccl_pkg::KEY_MAP[item_i.key_code] : 4'd0;
  assign busy     = (hold_q != kccl_pkg::HOLD_NONE) || (mode_q == kccl_pkg::PH_LOCKED);
  assign cnt_inc  = {1'b0, dcnt_q} + 4'd1;
  assign done     = cnt_inc >= CODE_LEN4;
  assign didx     = dcnt_q[IDX_W-1:0];
  assign fail_inc = (fail_q < kccl_pkg::FAIL_SAT) ? fail_q + 4'd1 : fail_q;
  assign hold_len = (cfg_i.hold_seconds == 8'd0) ? 8'd1 : cfg_i.hold_seconds;
  assign lock_len = (cfg_i.lockout_seconds == 8'd0) ? 8'd1 : cfg_i.lockout_seconds;
  assign htmr_dec = (htmr_q != 8'd0) ? htmr_q - 8'd1 : htmr_q;
  assign ltmr_dec = (ltmr_q != 8'd0) ? ltmr_q - 8'd1 : ltmr_q;

  always_comb begin
    code_match = 1'b1;
    for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
      if (IDX_W'(i) == didx) begin
        if (sym != enr_q[i]) code_match = 1'b0;
      end else if (ent_q[i] != enr_q[i]) begin
        code_match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    hold_d  = hold_q;
    dcnt_d  = dcnt_q;
    fail_d  = fail_q;
    htmr_d  = htmr_q;
    ltmr_d  = ltmr_q;
    pend_d  = pend_q;
    ev      = kccl_pkg::EV_NONE;
    enr_we  = 1'b0;
    ent_we  = 1'b0;
    card_we = 1'b0;
    case (req)
      kccl_pkg::REQ_KEY: begin
        if (busy) begin
          ev = kccl_pkg::EV_IGNORED;
        end else begin
          case (mode_q)
            kccl_pkg::PH_SET_PASS: begin
              enr_we = 1'b1;
              ev     = kccl_pkg::EV_KEY;
              dcnt_d = cnt_inc[2:0];
              if (done) begin
                dcnt_d = 3'd0;
                mode_d = kccl_pkg::PH_SET_CARD;
                hold_d = kccl_pkg::HOLD_LED;
                htmr_d = hold_len;
                ev     = kccl_pkg::EV_PASS_SET;
              end
            end
            kccl_pkg::PH_ENTRY: begin
              ent_we = 1'b1;
              ev     = kccl_pkg::EV_KEY;
              dcnt_d = cnt_inc[2:0];
              if (done) begin
                dcnt_d = 3'd0;
                htmr_d = hold_len;
                if (code_match) begin
                  hold_d = kccl_pkg::HOLD_RELAY;
                  ev     = kccl_pkg::EV_CODE_OK;
                end else begin
                  hold_d = kccl_pkg::HOLD_BUZZER;
                  fail_d = fail_inc;
                  if (fail_inc > cfg_i.max_failures) pend_d = 1'b1;
                  ev     = kccl_pkg::EV_CODE_BAD;
                end
              end
            end
            default: ev = kccl_pkg::EV_IGNORED;
          endcase
        end
      end
      kccl_pkg::REQ_CARD: begin
        if (busy) begin
          ev = kccl_pkg::EV_IGNORED;
        end else begin
          case (mode_q)
            kccl_pkg::PH_SET_CARD: begin
              card_we = 1'b1;
              mode_d  = kccl_pkg::PH_ENTRY;
              hold_d  = kccl_pkg::HOLD_LED;
              htmr_d  = hold_len;
              ev      = kccl_pkg::EV_CARD_SET;
            end
            kccl_pkg::PH_ENTRY: begin
              htmr_d = hold_len;
              if (item_i.card_id == card_q) begin
                hold_d = kccl_pkg::HOLD_RELAY;
                ev     = kccl_pkg::EV_CARD_OK;
              end else begin
                hold_d = kccl_pkg::HOLD_BUZZER;
                fail_d = fail_inc;
                if (fail_inc > cfg_i.max_failures) pend_d = 1'b1;
                ev     = kccl_pkg::EV_CARD_BAD;
              end
            end
            default: ev = kccl_pkg::EV_IGNORED;
          endcase
        end
      end
      kccl_pkg::REQ_TICK: begin
        if (hold_q != kccl_pkg::HOLD_NONE) begin
          htmr_d = htmr_dec;
          if (htmr_dec == 8'd0) begin
            hold_d = kccl_pkg::HOLD_NONE;
            if (pend_q) begin
              pend_d = 1'b0;
              fail_d = 4'd0;
              mode_d = kccl_pkg::PH_LOCKED;
              ltmr_d = lock_len;
              ev     = kccl_pkg::EV_LOCK_START;
            end
          end
        end else if (mode_q == kccl_pkg::PH_LOCKED) begin
          ltmr_d = ltmr_dec;
          if (ltmr_dec == 8'd0) begin
            mode_d = kccl_pkg::PH_ENTRY;
            ev     = kccl_pkg::EV_LOCK_END;
          end
        end
      end
      default: ev = kccl_pkg::EV_IGNORED;
    endcase
  end

  always_comb begin
    res_o.phase          = mode_d;
    res_o.event_code     = ev;
    res_o.key_symbol     = sym;
    res_o.relay_on       = hold_d == kccl_pkg::HOLD_RELAY;
    res_o.buzzer_on      = hold_d == kccl_pkg::HOLD_BUZZER;
    res_o.set_led_on     = hold_d == kccl_pkg::HOLD_LED;
    res_o.failures       = fail_d;
    res_o.lockout_left   = (mode_d == kccl_pkg::PH_LOCKED) ? ltmr_d : 8'd0;
    res_o.digits_entered = dcnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= kccl_pkg::PH_SET_PASS;
      hold_q <= kccl_pkg::HOLD_NONE;
      dcnt_q <= 3'd0;
      fail_q <= 4'd0;
      htmr_q <= 8'd0;
      ltmr_q <= 8'd0;
      pend_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      hold_q <= hold_d;
      dcnt_q <= dcnt_d;
      fail_q <= fail_d;
      htmr_q <= htmr_d;
      ltmr_q <= ltmr_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && enr_we) enr_q[didx] <= sym;
    if (step_i && ent_we) ent_q[didx] <= sym;
    if (step_i && card_we) card_q <= item_i.card_id;
  end

  a_dcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, dcnt_q} < CODE_LEN4)
    else $error("digit count reached code length");

  a_locked_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == kccl_pkg::PH_LOCKED |-> hold_q == kccl_pkg::HOLD_NONE)
    else $error("hold running during lockout");

  a_pend_buzzer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> hold_q == kccl_pkg::HOLD_BUZZER)
    else $error("lock pending without buzzer hold");

  a_hold_tmr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q != kccl_pkg::HOLD_NONE |-> htmr_q != 8'd0)
    else $error("hold active with empty timer");

  a_lock_tmr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == kccl_pkg::PH_LOCKED |-> ltmr_q != 8'd0)
    else $error("lockout with empty timer");

endmodule

>>> rtl/keypad_card_code_lock.sv
// Keypad and card door lock: request register, configuration, result register.
//
// Requests (key press, card, one-second tick) arrive as beats on the in channel
// (in_valid_i / in_ready_o / in_data_i). Every request gives exactly one result
// beat on the out channel (out_valid_o / out_ready_i / out_data_o) carrying the
// phase, event code, mapped key and drive levels after that request.
// A request is captured in the input register at acceptance and processed from
// there into the result register when it is free. One request per cycle is
// sustained while the receiver takes each result; the limit is the single state
// update between the two registers. When the receiver stalls, the result
// register holds its beat and one further request waits in the input register;
// in_ready_o then drops until out_ready_i returns. Configuration registers are
// written with cfg_we_i, cfg_idx_i and cfg_wdata_i only while no request is in
// flight, a rule for the user that the block does not enforce; unknown indexes
// are dropped. Reset enters password enrollment with zero counts, no hold and
// the default configuration (3 failures, 10 lockout ticks, 3 hold ticks).
module keypad_card_code_lock #(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  kccl_pkg::kccl_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output kccl_pkg::kccl_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [kccl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kccl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  logic                in_vld_q;
  kccl_pkg::kccl_in_t  in_q;
  logic                out_vld_q;
  kccl_pkg::kccl_out_t out_q;
  kccl_pkg::kccl_out_t res;
  kccl_pkg::kccl_cfg_t cfg_q;
  logic                step;

  assign step        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || step;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  kccl_core #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(in_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
    if (step) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_failures    <= kccl_pkg::MAX_FAILURES_RST;
      cfg_q.lockout_seconds <= kccl_pkg::LOCKOUT_SECONDS_RST;
      cfg_q.hold_seconds    <= kccl_pkg::HOLD_SECONDS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kccl_pkg::CFG_MAX_FAILURES:    cfg_q.max_failures    <= cfg_wdata_i[3:0];
        kccl_pkg::CFG_LOCKOUT_SECONDS: cfg_q.lockout_seconds <= cfg_wdata_i;
        kccl_pkg::CFG_HOLD_SECONDS:    cfg_q.hold_seconds    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

endmodule
